/* rtl/epo_pkg.sv */
// ----------------------------------------------------------------------------
// epo_pkg: shared types of the ellipsoid pair overlap block
// Contact kind codes reported with every result.
// ----------------------------------------------------------------------------
package epo_pkg;

    typedef enum logic [2:0] {
        KIND_NONE        = 3'd0,
        KIND_FIRST_TIP   = 3'd1,
        KIND_FIRST_SIDE  = 3'd2,
        KIND_SECOND_TIP  = 3'd3,
        KIND_SECOND_SIDE = 3'd4
    } contact_kind_t;

endpackage

/* rtl/ellipsoid_pair_overlap_top.sv */
// ----------------------------------------------------------------------------
// ellipsoid_pair_overlap_top: collision test of two upright half-ellipsoids
// Pipelined pair test with tip/side contact kind and push vector output.
// ----------------------------------------------------------------------------
// Usage:
//   One request on the s_ channel carries both ellipsoids (bottom center,
//   bottom radius, height, raw fixed point). One result leaves on the m_
//   channel for each request: contact kind and the push (move_x/y/z) for the
//   first ellipsoid, saturated to COORD_BITS.
//   Throughput: one request per clock while the pipeline is not held. The
//   pipeline is set by the two bit-per-stage square roots (COORD_BITS+1
//   stages), the half-width divider (COORD_BITS-1 stages) and the push
//   divider (COORD_BITS stages). The last stage drains into a two-entry
//   output buffer; while it has room the pipeline keeps advancing and
//   s_tready stays high, so a waiting result does not block new requests.
//   With the buffer full and m_tready low the whole pipeline holds;
//   nothing is dropped or repeated. Reset clears all valid bits and the
//   output buffer; payload registers are left as they are.
module ellipsoid_pair_overlap_top
    import epo_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // first_x, first_y, first_z, first_radius, first_height,
    // second_x, second_y, second_z, second_radius, second_height
    input  logic [((10*COORD_BITS-4+7)/8)*8-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // contact_kind, move_x, move_y, move_z
    output logic [((3*COORD_BITS+3+7)/8)*8-1:0]    m_tdata
);

    localparam int CW       = COORD_BITS;
    localparam int PW       = 2*CW+2;
    localparam int RW       = CW+3;
    localparam int H        = (CW+1)/2;
    localparam int ODW      = ((3*CW+3+7)/8)*8;

    localparam int OFF_FX = 0;
    localparam int OFF_FY = CW;
    localparam int OFF_FZ = 2*CW;
    localparam int OFF_FR = 3*CW;
    localparam int OFF_FH = 4*CW-1;
    localparam int OFF_SX = 5*CW-2;
    localparam int OFF_SY = 6*CW-2;
    localparam int OFF_SZ = 7*CW-2;
    localparam int OFF_SR = 8*CW-2;
    localparam int OFF_SH = 9*CW-3;

    localparam int N_SQRT = CW+1;
    localparam int N_DIV1 = CW-1;
    localparam int N_DIV2 = CW;

    localparam int S_A  = 0;
    localparam int S_B  = 1;
    localparam int S_C  = 2;
    localparam int S_D  = 3;
    localparam int S_E  = 4;
    localparam int S_SQ = 5;
    localparam int S_F  = S_SQ+N_SQRT;
    localparam int S_G  = S_F+1;
    localparam int S_DH = S_G+1;
    localparam int S_H  = S_DH+N_DIV1;
    localparam int S_I  = S_H+1;
    localparam int S_J  = S_I+1;
    localparam int S_DM = S_J+1;
    localparam int S_K  = S_DM+N_DIV2;
    localparam int NST  = S_K+1;

    typedef struct packed {
        logic                   swapped;
        logic                   contact;
        logic                   tip;
        logic                   side_ok;
        logic                   lh_zero;
        logic [CW:0]            dx;
        logic [CW:0]            dz;
        logic [CW:0]            ax;
        logic [CW:0]            az;
        logic [CW:0]            d;
        logic [CW-1:0]          bd;
        logic [CW-1:0]          olap;
        logic [CW-2:0]          ur;
        logic [CW-2:0]          lr;
        logic [CW-2:0]          lh;
        logic [CW-2:0]          tipmag;
        logic [3:0][PW-1:0]     mul_lo;
        logic [3:0][PW-1:0]     mul_hi;
        logic [1:0][PW-1:0]     rad;
        logic [1:0][RW-1:0]     rem;
        logic [1:0][CW:0]       root;
        contact_kind_t          kind;
        logic [2:0][CW-1:0]     mv;
    } pipe_t;

    function automatic logic [CW-1:0] sat_coord(input logic [CW+1:0] v);
        logic [CW-1:0] r;
        if (v[CW+1:CW-1] == '0 || v[CW+1:CW-1] == '1)
        begin
            r = v[CW-1:0];
        end
        else if (v[CW+1])
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    pipe_t            st_reg  [NST];
    pipe_t            st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             en;

    logic [ODW-1:0]   fifo_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             push;
    logic             pop;
    logic [ODW-1:0]   out_word;

    // advance the whole pipeline while the output buffer can take a result
    assign en       = (cnt_reg != 2'd2) || m_tready;
    assign s_tready = en;

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            pipe_t nx;
            assign st_next[k] = nx;

            if (k == S_A)
            begin : g_a
                // pick upper and lower, take center differences
                logic [CW-1:0] fy, sy, ux, uy, uz, lx, ly, lz;
                logic [CW:0]   bd_w;
                always_comb
                begin
                    nx = '0;
                    fy = s_tdata[OFF_FY +: CW];
                    sy = s_tdata[OFF_SY +: CW];
                    nx.swapped = !($signed(fy) > $signed(sy));
                    if (nx.swapped)
                    begin
                        ux = s_tdata[OFF_SX +: CW];
                        uy = sy;
                        uz = s_tdata[OFF_SZ +: CW];
                        lx = s_tdata[OFF_FX +: CW];
                        ly = fy;
                        lz = s_tdata[OFF_FZ +: CW];
                        nx.ur = s_tdata[OFF_SR +: CW-1];
                        nx.lr = s_tdata[OFF_FR +: CW-1];
                        nx.lh = s_tdata[OFF_FH +: CW-1];
                    end
                    else
                    begin
                        ux = s_tdata[OFF_FX +: CW];
                        uy = fy;
                        uz = s_tdata[OFF_FZ +: CW];
                        lx = s_tdata[OFF_SX +: CW];
                        ly = sy;
                        lz = s_tdata[OFF_SZ +: CW];
                        nx.ur = s_tdata[OFF_FR +: CW-1];
                        nx.lr = s_tdata[OFF_SR +: CW-1];
                        nx.lh = s_tdata[OFF_SH +: CW-1];
                    end
                    nx.dx = {ux[CW-1], ux} - {lx[CW-1], lx};
                    nx.dz = {uz[CW-1], uz} - {lz[CW-1], lz};
                    bd_w  = {uy[CW-1], uy} - {ly[CW-1], ly};
                    nx.bd = bd_w[CW-1:0];
                end
            end
            else if (k == S_B)
            begin : g_b
                always_comb
                begin
                    nx = st_reg[k-1];
                    nx.ax = nx.dx[CW] ? (CW+1)'(-nx.dx) : nx.dx;
                    nx.az = nx.dz[CW] ? (CW+1)'(-nx.dz) : nx.dz;
                end
            end
            else if (k == S_C)
            begin : g_c
                // split squares into two partial products each
                always_comb
                begin
                    nx = st_reg[k-1];
                    nx.mul_lo[0] = PW'(nx.ax * nx.ax[H-1:0]);
                    nx.mul_hi[0] = PW'(nx.ax * nx.ax[CW:H]);
                    nx.mul_lo[1] = PW'(nx.az * nx.az[H-1:0]);
                    nx.mul_hi[1] = PW'(nx.az * nx.az[CW:H]);
                    nx.mul_lo[2] = PW'(nx.lh * nx.lh[H-1:0]);
                    nx.mul_hi[2] = PW'(nx.lh * nx.lh[CW-2:H]);
                    nx.mul_lo[3] = PW'(nx.bd[CW-2:0] * nx.bd[H-1:0]);
                    nx.mul_hi[3] = PW'(nx.bd[CW-2:0] * nx.bd[CW-2:H]);
                end
            end
            else if (k == S_D)
            begin : g_d
                always_comb
                begin
                    nx = st_reg[k-1];
                    for (int i = 0; i < 4; i++)
                    begin
                        nx.mul_lo[i] = nx.mul_lo[i] + (nx.mul_hi[i] << H);
                    end
                end
            end
            else if (k == S_E)
            begin : g_e
                always_comb
                begin
                    nx = st_reg[k-1];
                    nx.rad[0]  = nx.mul_lo[0] + nx.mul_lo[1];
                    nx.rad[1]  = nx.mul_lo[2] - nx.mul_lo[3];
                    nx.rem     = '0;
                    nx.root    = '0;
                end
            end
            else if (k >= S_SQ && k < S_F)
            begin : g_sqrt
                // one root bit per stage for both radicands
                logic [1:0][RW+1:0] sh, t;
                always_comb
                begin
                    nx = st_reg[k-1];
                    for (int i = 0; i < 2; i++)
                    begin
                        sh[i] = {nx.rem[i], nx.rad[i][PW-1:PW-2]};
                        t[i]  = (RW+2)'({nx.root[i], 2'b01});
                        if (sh[i] >= t[i])
                        begin
                            nx.rem[i]  = RW'(sh[i] - t[i]);
                            nx.root[i] = {nx.root[i][CW-1:0], 1'b1};
                        end
                        else
                        begin
                            nx.rem[i]  = RW'(sh[i]);
                            nx.root[i] = {nx.root[i][CW-1:0], 1'b0};
                        end
                        nx.rad[i] = nx.rad[i] << 2;
                    end
                end
            end
            else if (k == S_F)
            begin : g_f
                always_comb
                begin
                    nx = st_reg[k-1];
                    nx.d       = nx.root[0];
                    nx.contact = nx.bd <= CW'(nx.lh);
                    nx.tip     = nx.root[0] <= (CW+1)'(nx.ur);
                    nx.lh_zero = nx.lh == '0;
                    nx.tipmag  = nx.lh - nx.bd[CW-2:0];
                    nx.mul_lo[0] = PW'(nx.lr * nx.root[1][H-1:0]);
                    nx.mul_hi[0] = PW'(nx.lr * nx.root[1][CW-2:H]);
                end
            end
            else if (k == S_G)
            begin : g_g
                logic [PW-1:0] num;
                always_comb
                begin
                    nx = st_reg[k-1];
                    num        = nx.mul_lo[0] + (nx.mul_hi[0] << H);
                    nx.rem[0]  = RW'(num[2*CW-3:CW-1]);
                    nx.rad[0]  = num << (CW+3);
                    nx.root[0] = '0;
                end
            end
            else if (k >= S_DH && k < S_H)
            begin : g_div_half
                // one quotient bit per stage, divide by lower height
                logic [RW-1:0] sh, dv;
                always_comb
                begin
                    nx = st_reg[k-1];
                    sh = {nx.rem[0][RW-2:0], nx.rad[0][PW-1]};
                    dv = RW'(nx.lh);
                    if (sh >= dv)
                    begin
                        nx.rem[0]  = sh - dv;
                        nx.root[0] = {nx.root[0][CW-1:0], 1'b1};
                    end
                    else
                    begin
                        nx.rem[0]  = sh;
                        nx.root[0] = {nx.root[0][CW-1:0], 1'b0};
                    end
                    nx.rad[0] = nx.rad[0] << 1;
                end
            end
            else if (k == S_H)
            begin : g_h
                logic [CW-2:0] half;
                logic [CW+1:0] olap_s;
                always_comb
                begin
                    nx = st_reg[k-1];
                    half = nx.lh_zero ? nx.lr : nx.root[0][CW-2:0];
                    olap_s = (CW+2)'(nx.ur) + (CW+2)'(half) - (CW+2)'(nx.d);
                    nx.side_ok = !olap_s[CW+1];
                    nx.olap    = olap_s[CW-1:0];
                end
            end
            else if (k == S_I)
            begin : g_i
                always_comb
                begin
                    nx = st_reg[k-1];
                    nx.mul_lo[0] = PW'(nx.ax * nx.olap[H-1:0]);
                    nx.mul_hi[0] = PW'(nx.ax * nx.olap[CW-1:H]);
                    nx.mul_lo[1] = PW'(nx.az * nx.olap[H-1:0]);
                    nx.mul_hi[1] = PW'(nx.az * nx.olap[CW-1:H]);
                end
            end
            else if (k == S_J)
            begin : g_j
                logic [1:0][PW-1:0] num;
                always_comb
                begin
                    nx = st_reg[k-1];
                    for (int i = 0; i < 2; i++)
                    begin
                        num[i]     = nx.mul_lo[i] + (nx.mul_hi[i] << H);
                        nx.rem[i]  = RW'(num[i][2*CW:CW]);
                        nx.rad[i]  = num[i] << (CW+2);
                        nx.root[i] = '0;
                    end
                end
            end
            else if (k >= S_DM && k < S_K)
            begin : g_div_move
                // one quotient bit per stage, divide by center distance
                logic [1:0][RW-1:0] sh;
                logic [RW-1:0]      dv;
                always_comb
                begin
                    nx = st_reg[k-1];
                    dv = RW'(nx.d);
                    for (int i = 0; i < 2; i++)
                    begin
                        sh[i] = {nx.rem[i][RW-2:0], nx.rad[i][PW-1]};
                        if (sh[i] >= dv)
                        begin
                            nx.rem[i]  = sh[i] - dv;
                            nx.root[i] = {nx.root[i][CW-1:0], 1'b1};
                        end
                        else
                        begin
                            nx.rem[i]  = sh[i];
                            nx.root[i] = {nx.root[i][CW-1:0], 1'b0};
                        end
                        nx.rad[i] = nx.rad[i] << 1;
                    end
                end
            end
            else
            begin : g_k
                // pick the kind, sign the push, saturate
                logic          is_tip, is_side;
                logic [CW+1:0] vx, vy, vz;
                always_comb
                begin
                    nx = st_reg[k-1];
                    is_tip  = nx.contact && nx.tip;
                    is_side = nx.contact && !nx.tip && nx.side_ok;
                    if (is_tip)
                    begin
                        nx.kind = nx.swapped ? KIND_SECOND_TIP : KIND_FIRST_TIP;
                    end
                    else if (is_side)
                    begin
                        nx.kind = nx.swapped ? KIND_SECOND_SIDE : KIND_FIRST_SIDE;
                    end
                    else
                    begin
                        nx.kind = KIND_NONE;
                    end
                    vx = is_side ? (CW+2)'(nx.root[0][CW-1:0]) : '0;
                    vz = is_side ? (CW+2)'(nx.root[1][CW-1:0]) : '0;
                    vy = is_tip  ? (CW+2)'(nx.tipmag) : '0;
                    if (nx.dx[CW] ^ nx.swapped)
                    begin
                        vx = -vx;
                    end
                    if (nx.dz[CW] ^ nx.swapped)
                    begin
                        vz = -vz;
                    end
                    if (nx.swapped)
                    begin
                        vy = -vy;
                    end
                    nx.mv[0] = sat_coord(vx);
                    nx.mv[1] = sat_coord(vy);
                    nx.mv[2] = sat_coord(vz);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[k] <= st_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // output buffer: two entries so the pipeline keeps moving under a stall
    assign out_word = ODW'({st_reg[NST-1].mv[2], st_reg[NST-1].mv[1],
                            st_reg[NST-1].mv[0], st_reg[NST-1].kind});
    assign push     = en && vld_reg[NST-1];
    assign m_tvalid = cnt_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= out_word;
        end
    end

endmodule

/* tb/ellipsoid_pair_overlap_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ellipsoid_pair_overlap_top_tb: self-checking bench of the pair overlap block
// Drives pair requests through the slave stream, predicts contact kind and
// push for each accepted request and checks the master stream in order,
// under several idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module ellipsoid_pair_overlap_top_tb;
    import epo_pkg::*;

    localparam int CB         = 32;
    localparam int SW         = ((10*CB-4+7)/8)*8;
    localparam int MW         = ((3*CB+3+7)/8)*8;
    localparam int LATENCY    = 3*CB+11;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 500;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [30:0]        r, h;
    } ellip_t;

    typedef struct {
        contact_kind_t kind;
        logic [31:0]   mx, my, mz;
    } contact_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;

    logic [SW-1:0] pair_q[$];
    contact_t      contact_q[$];
    int            send_idle = 0;
    int            recv_stall = 0;
    bit            hold_req = 1'b0;
    bit            hold_taken = 1'b0;
    int            hold_left = 0;
    int            idle_cycles = 0;
    int            errors = 0;

    ellipsoid_pair_overlap_top #(.COORD_BITS(CB)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Pack one request: x, y, z, radius, height of first, then of second.
    function automatic logic [SW-1:0] pack_pair(ellip_t a, ellip_t b);
        return {4'b0, b.h, b.r, b.z, b.y, b.x, a.h, a.r, a.z, a.y, a.x};
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            sq = {64'd0, trial} * {64'd0, trial};
            if (sq <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] clamp_coord(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Expected contact for one request.
    function automatic contact_t predict_contact(logic [SW-1:0] p);
        logic signed [63:0] fx, fy, fz, sx, sy, sz;
        logic signed [63:0] ux, uy, uz, lx, ly, lz;
        logic signed [63:0] dx, dz, bd, olap, half_w;
        logic signed [63:0] mv[3];
        logic [63:0]        ur, lr, lh, ax, az, cdist, root;
        logic [127:0]       prod;
        bit                 swapped;
        contact_t           res;
        fx = 64'($signed(p[31:0]));
        fy = 64'($signed(p[63:32]));
        fz = 64'($signed(p[95:64]));
        sx = 64'($signed(p[189:158]));
        sy = 64'($signed(p[221:190]));
        sz = 64'($signed(p[253:222]));
        swapped = !(fy > sy);
        if (!swapped)
        begin
            ux = fx; uy = fy; uz = fz; lx = sx; ly = sy; lz = sz;
            ur = 64'(p[126:96]); lr = 64'(p[284:254]); lh = 64'(p[315:285]);
        end
        else
        begin
            ux = sx; uy = sy; uz = sz; lx = fx; ly = fy; lz = fz;
            ur = 64'(p[284:254]); lr = 64'(p[126:96]); lh = 64'(p[157:127]);
        end
        dx = ux - lx;
        dz = uz - lz;
        bd = uy - ly;
        ax = dx < 0 ? -dx : dx;
        az = dz < 0 ? -dz : dz;
        cdist = floor_sqrt({64'd0, ax} * {64'd0, ax} + {64'd0, az} * {64'd0, az});
        mv[0] = 0; mv[1] = 0; mv[2] = 0;
        res.kind = KIND_NONE;
        if ($unsigned(bd) <= lh)
        begin
            if (cdist <= ur)
            begin
                res.kind = KIND_FIRST_TIP;
                mv[1] = lh - bd;
            end
            else
            begin
                // flat lower ellipsoid touched at its bottom: full radius
                if (lh == 0)
                    half_w = lr;
                else
                begin
                    root = floor_sqrt({64'd0, lh} * {64'd0, lh}
                                      - {64'd0, bd} * {64'd0, bd});
                    prod = ({64'd0, lr} * {64'd0, root}) / {64'd0, lh};
                    half_w = prod[63:0];
                end
                olap = $signed(ur) + half_w - $signed(cdist);
                if (olap >= 0)
                begin
                    res.kind = KIND_FIRST_SIDE;
                    prod = ({64'd0, ax} * {64'd0, olap}) / {64'd0, cdist};
                    mv[0] = dx < 0 ? -$signed(prod[63:0]) : $signed(prod[63:0]);
                    prod = ({64'd0, az} * {64'd0, olap}) / {64'd0, cdist};
                    mv[2] = dz < 0 ? -$signed(prod[63:0]) : $signed(prod[63:0]);
                end
            end
        end
        if (swapped)
        begin
            for (int i = 0; i < 3; i++)
                mv[i] = -mv[i];
            if (res.kind == KIND_FIRST_TIP)
                res.kind = KIND_SECOND_TIP;
            else if (res.kind == KIND_FIRST_SIDE)
                res.kind = KIND_SECOND_SIDE;
        end
        res.mx = clamp_coord(mv[0]);
        res.my = clamp_coord(mv[1]);
        res.mz = clamp_coord(mv[2]);
        return res;
    endfunction

    // Driver: advance to the next request once the current one is taken,
    // record the prediction at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                contact_q.push_back(predict_contact(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pair_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pair_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest prediction, drive
    // m_tready with random stalls or the one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        contact_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (contact_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected result kind=%0d", m_tdata[2:0]);
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (m_tdata[2:0] !== want.kind)
                    begin
                        errors++;
                        $error("contact_kind exp %0d got %0d", want.kind, m_tdata[2:0]);
                    end
                    if (m_tdata[34:3] !== want.mx)
                    begin
                        errors++;
                        $error("move_x exp %0d got %0d",
                               $signed(want.mx), $signed(m_tdata[34:3]));
                    end
                    if (m_tdata[66:35] !== want.my)
                    begin
                        errors++;
                        $error("move_y exp %0d got %0d",
                               $signed(want.my), $signed(m_tdata[66:35]));
                    end
                    if (m_tdata[98:67] !== want.mz)
                    begin
                        errors++;
                        $error("move_z exp %0d got %0d",
                               $signed(want.mz), $signed(m_tdata[98:67]));
                    end
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_LEN;
                m_tready   <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // Watchdog: count cycles without any handshake while work is pending.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (pair_q.size() > 0 || s_tvalid || contact_q.size() > 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ellipsoid_pair_overlap_top test failed");
            $finish;
        end
    end

    function automatic ellip_t mk(longint x, longint y, longint z, longint r, longint h);
        ellip_t e;
        e.x = 32'(x); e.y = 32'(y); e.z = 32'(z); e.r = 31'(r); e.h = 31'(h);
        return e;
    endfunction

    // Random pair: mostly a near pair at a random scale so that contacts of
    // both kinds happen, the rest raw noise over the full field ranges.
    function automatic logic [SW-1:0] random_pair();
        ellip_t a, b;
        int     sc;
        int     sel;
        logic [31:0] m;
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            a = mk($signed($urandom), $signed($urandom), $signed($urandom),
                   $urandom & 32'h7fff_ffff, $urandom & 32'h7fff_ffff);
            b = mk($signed($urandom), $signed($urandom), $signed($urandom),
                   $urandom & 32'h7fff_ffff, $urandom & 32'h7fff_ffff);
        end
        else
        begin
            sc = $urandom_range(3, 28);
            m = (32'd1 << sc) - 1;
            b.x = $signed($urandom) >>> 2;
            b.y = $signed($urandom) >>> 2;
            b.z = $signed($urandom) >>> 2;
            b.r = 31'(($urandom & m) | 32'd1);
            b.h = 31'(($urandom & m) | 32'd1);
            a.r = 31'(($urandom & m) | 32'd1);
            a.h = 31'(($urandom & m) | 32'd1);
            a.x = 32'(b.x + $signed($urandom & {m, 1'b1}) - $signed({1'b0, m}));
            a.z = 32'(b.z + $signed($urandom & {m, 1'b1}) - $signed({1'b0, m}));
            // hold equal bottoms sometimes to hit the tie rule
            if (sel < 30)
                a.y = b.y;
            else
                a.y = 32'(b.y + $signed($urandom & {m, 1'b1}) - $signed({1'b0, m}));
        end
        return pack_pair(a, b);
    endfunction

    task automatic wait_drained();
        while (pair_q.size() > 0 || s_tvalid || contact_q.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_random(int n, int sidle, int rstall);
        send_idle  = sidle;
        recv_stall = rstall;
        for (int i = 0; i < n; i++)
            pair_q.push_back(random_pair());
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // directed: tip, side, ties, flat lower body, zero overlap, saturation
        pair_q.push_back(pack_pair(mk(0, 10, 0, 5, 5), mk(0, 0, 0, 5, 20)));
        pair_q.push_back(pack_pair(mk(0, 0, 0, 5, 20), mk(0, 10, 0, 5, 5)));
        pair_q.push_back(pack_pair(mk(3, 7, 4, 5, 9), mk(0, 7, 0, 6, 9)));
        pair_q.push_back(pack_pair(mk(30, 5, -7, 10, 5), mk(0, 0, 0, 30, 10)));
        pair_q.push_back(pack_pair(mk(0, 0, 0, 30, 10), mk(-30, 5, 7, 10, 5)));
        pair_q.push_back(pack_pair(mk(0, 50, 0, 5, 5), mk(0, 0, 0, 5, 20)));
        pair_q.push_back(pack_pair(mk(1000, 1, 0, 5, 5), mk(0, 0, 0, 5, 20)));
        pair_q.push_back(pack_pair(mk(20, 0, 0, 10, 0), mk(0, 0, 0, 15, 5)));
        pair_q.push_back(pack_pair(mk(30, 0, 0, 10, 5), mk(0, -1, 0, 20, 0)));
        pair_q.push_back(pack_pair(mk(0, 0, 0, 20, 10), mk(30, 0, 0, 10, 5)));
        pair_q.push_back(pack_pair(mk(1073741825, 1, 0, 1073741824, 5),
                                   mk(0, 0, 0, 2147483647, 2147483647)));
        pair_q.push_back(pack_pair(mk(0, 0, 0, 2147483647, 2147483647),
                                   mk(1073741825, 1, 0, 1073741824, 5)));
        pair_q.push_back(pack_pair(mk(0, 0, 1073741825, 2147483647, 2147483647),
                                   mk(0, 1, 0, 1073741824, 5)));
        pair_q.push_back(pack_pair(mk(2147483647, 2147483647, 2147483647,
                                      2147483647, 2147483647),
                                   mk(-2147483648, -2147483648, -2147483648,
                                      2147483647, 2147483647)));
        pair_q.push_back(pack_pair(mk(-2147483648, -2147483648, -2147483648, 0, 0),
                                   mk(2147483647, 2147483647, 2147483647, 0, 0)));
        pair_q.push_back(pack_pair(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0)));
        pair_q.push_back(pack_pair(mk(5, 0, 0, 0, 0), mk(0, 0, 0, 5, 0)));
        pair_q.push_back(pack_pair(mk(0, 2147483647, 0, 1, 1),
                                   mk(0, -2147483648, 0, 1, 2147483647)));
        wait_drained();

        run_random(380, 0, 0);
        run_random(380, 63, 0);
        run_random(380, 0, 63);
        run_random(380, 10, 10);

        // long output hold-off while requests keep coming
        hold_req = 1'b1;
        run_random(380, 0, 0);

        repeat (LATENCY + 40) @(negedge clk);
        if (errors == 0 && contact_q.size() == 0)
            $display("ellipsoid_pair_overlap_top test passed");
        else
            $display("ellipsoid_pair_overlap_top test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/epo_pkg.sv
rtl/ellipsoid_pair_overlap_top.sv
tb/ellipsoid_pair_overlap_top_tb.sv
